@@ design/asag_pkg.sv @@
// Shared types and constants for the affine span source address generator.
// Used by asag_ctrl, asag_datapath and the top level; depends on nothing.
`default_nettype none

package asag_pkg;

  localparam int unsigned CoefW  = 32;  // 16.16 matrix entries and accumulators
  localparam int unsigned CoordW = 16;  // destination coordinates
  localparam int unsigned LenW   = 7;   // span length field
  localparam int unsigned DimW   = 13;  // source width and height registers
  localparam int unsigned AddrW  = 24;  // source address
  localparam int unsigned IdxW   = 3;   // configuration register index

  typedef enum logic [IdxW-1:0] {
    REG_COEF_XX   = 3'd0,
    REG_COEF_XY   = 3'd1,
    REG_OFFSET_X  = 3'd2,
    REG_COEF_YX   = 3'd3,
    REG_COEF_YY   = 3'd4,
    REG_OFFSET_Y  = 3'd5,
    REG_SRC_WIDTH = 3'd6,
    REG_SRC_HEIGHT = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_AX,
    S_MAP_BY,
    S_MAP_DX,
    S_MAP_EY,
    S_MAP_END,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MUL_AX,
    MUL_BY,
    MUL_DX,
    MUL_EY
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_X,
    ACC_ADD_Y
  } acc_op_e;

  typedef struct packed {
    logic     load;     // latch a new span request
    mul_sel_e mul_sel;  // operand pair for the shared multiplier
    acc_op_e  acc_op;   // accumulator action this cycle
    logic     pix_gen;  // issue one pixel and step the accumulators
  } cmd_t;

  typedef struct packed {
    logic gen_ok;    // first pixel stage can take a pixel
    logic cnt_last;  // one pixel left
    logic cnt_zero;  // no pixels left
  } sts_t;

endpackage

`default_nettype wire

@@ design/asag_ctrl.sv @@
// Sequencer for the affine span source address generator.
// Drives the datapath through asag_pkg::cmd_t and watches asag_pkg::sts_t.
`default_nettype none

module asag_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output asag_pkg::cmd_t     cmd_o,
  input  wire asag_pkg::sts_t sts_i
);

  asag_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asag_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The start point is mapped with one multiplier: four products, each registered
  // in prod_q and then summed into its accumulator.
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.load     = 1'b0;
    cmd_o.mul_sel  = asag_pkg::MUL_AX;
    cmd_o.acc_op   = asag_pkg::ACC_HOLD;
    cmd_o.pix_gen  = 1'b0;
    case (state_q)
      asag_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = asag_pkg::S_MAP_AX;
        end
      end
      asag_pkg::S_MAP_AX: begin
        cmd_o.mul_sel = asag_pkg::MUL_AX;
        cmd_o.acc_op  = asag_pkg::ACC_LOAD;
        state_d       = asag_pkg::S_MAP_BY;
      end
      asag_pkg::S_MAP_BY: begin
        cmd_o.mul_sel = asag_pkg::MUL_BY;
        cmd_o.acc_op  = asag_pkg::ACC_ADD_X;
        state_d       = asag_pkg::S_MAP_DX;
      end
      asag_pkg::S_MAP_DX: begin
        cmd_o.mul_sel = asag_pkg::MUL_DX;
        cmd_o.acc_op  = asag_pkg::ACC_ADD_X;
        state_d       = asag_pkg::S_MAP_EY;
      end
      asag_pkg::S_MAP_EY: begin
        cmd_o.mul_sel = asag_pkg::MUL_EY;
        cmd_o.acc_op  = asag_pkg::ACC_ADD_Y;
        state_d       = asag_pkg::S_MAP_END;
      end
      asag_pkg::S_MAP_END: begin
        cmd_o.acc_op = asag_pkg::ACC_ADD_Y;
        state_d      = sts_i.cnt_zero ? asag_pkg::S_IDLE : asag_pkg::S_EMIT;
      end
      asag_pkg::S_EMIT: begin
        if (sts_i.gen_ok) begin
          cmd_o.pix_gen = 1'b1;
          if (sts_i.cnt_last) begin
            state_d = asag_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = asag_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/asag_datapath.sv @@
// Datapath: configuration registers, start point mapping, accumulators,
// pixel counter and the two-stage bounds and address pipeline.
// Uses asag_pkg for widths, register codes and the command and status types.
`default_nettype none

module asag_datapath #(
  parameter int unsigned MAX_SPAN = 64,
  parameter int unsigned MAX_DIM  = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  input  wire logic [asag_pkg::IdxW-1:0]       cfg_index_i,
  input  wire logic [asag_pkg::CoefW-1:0]      cfg_data_i,
  input  wire logic signed [asag_pkg::CoordW-1:0] start_x_i,
  input  wire logic signed [asag_pkg::CoordW-1:0] start_y_i,
  input  wire logic [asag_pkg::LenW-1:0]       span_length_i,
  input  wire asag_pkg::cmd_t                  cmd_i,
  output asag_pkg::sts_t                       sts_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [asag_pkg::AddrW-1:0]           source_address_o,
  output logic                                 inside_res_o,
  output logic                                 last_o
);

  localparam int unsigned CntW = $clog2(MAX_SPAN + 1);
  localparam logic [31:0] MaxDimW  = 32'(MAX_DIM);
  localparam logic [31:0] MaxSpanW = 32'(MAX_SPAN);

  localparam int unsigned CW = asag_pkg::CoefW;
  localparam int unsigned XW = asag_pkg::CoordW;
  localparam int unsigned DW = asag_pkg::DimW;

  // Configuration registers
  logic [CW-1:0] coef_xx_q, coef_xy_q, offset_x_q, coef_yx_q, coef_yy_q, offset_y_q;
  logic [DW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q  <= CW'(32'h0001_0000);
      coef_xy_q  <= '0;
      offset_x_q <= '0;
      coef_yx_q  <= '0;
      coef_yy_q  <= CW'(32'h0001_0000);
      offset_y_q <= '0;
      width_q    <= DW'(1);
      height_q   <= DW'(1);
    end else if (cfg_valid_i) begin
      case (asag_pkg::cfg_reg_e'(cfg_index_i))
        asag_pkg::REG_COEF_XX:    coef_xx_q  <= cfg_data_i;
        asag_pkg::REG_COEF_XY:    coef_xy_q  <= cfg_data_i;
        asag_pkg::REG_OFFSET_X:   offset_x_q <= cfg_data_i;
        asag_pkg::REG_COEF_YX:    coef_yx_q  <= cfg_data_i;
        asag_pkg::REG_COEF_YY:    coef_yy_q  <= cfg_data_i;
        asag_pkg::REG_OFFSET_Y:   offset_y_q <= cfg_data_i;
        asag_pkg::REG_SRC_WIDTH:  width_q    <= cfg_data_i[DW-1:0];
        asag_pkg::REG_SRC_HEIGHT: height_q   <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  // Clamped source dimensions
  logic [DW-1:0] w_c, h_c;
  assign w_c = ({{(32-DW){1'b0}}, width_q} > MaxDimW) ? MaxDimW[DW-1:0] : width_q;
  assign h_c = ({{(32-DW){1'b0}}, height_q} > MaxDimW) ? MaxDimW[DW-1:0] : height_q;

  // Span request and pixel counter
  logic signed [XW-1:0] x_q, y_q;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      len_sat;

  assign len_sat = ({{(32-asag_pkg::LenW){1'b0}}, span_length_i} > MaxSpanW)
                   ? MaxSpanW[CntW-1:0] : CntW'(span_length_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= start_x_i;
      y_q <= start_y_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cnt_d = len_sat;
    end else if (cmd_i.pix_gen) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Shared multiplier: a 16.16 coefficient times an integer coordinate in
  // 16.16 reduces to the low 32 bits of coefficient times coordinate.
  logic signed [CW-1:0]    mul_a;
  logic signed [XW-1:0]    mul_b;
  logic signed [CW+XW-1:0] mul_full;
  logic [CW-1:0]           prod_q;

  always_comb begin
    case (cmd_i.mul_sel)
      asag_pkg::MUL_AX: begin mul_a = coef_xx_q; mul_b = x_q; end
      asag_pkg::MUL_BY: begin mul_a = coef_xy_q; mul_b = y_q; end
      asag_pkg::MUL_DX: begin mul_a = coef_yx_q; mul_b = x_q; end
      asag_pkg::MUL_EY: begin mul_a = coef_yy_q; mul_b = y_q; end
      default:          begin mul_a = coef_xx_q; mul_b = x_q; end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[CW-1:0];
  end

  // Source position accumulators
  logic [CW-1:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;

  always_comb begin
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    case (cmd_i.acc_op)
      asag_pkg::ACC_LOAD: begin
        acc_x_d = offset_x_q;
        acc_y_d = offset_y_q;
      end
      asag_pkg::ACC_ADD_X: acc_x_d = acc_x_q + prod_q;
      asag_pkg::ACC_ADD_Y: acc_y_d = acc_y_q + prod_q;
      default: ;
    endcase
    if (cmd_i.pix_gen) begin
      acc_x_d = acc_x_q + coef_xx_q;
      acc_y_d = acc_y_q + coef_yx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else begin
      acc_x_q <= acc_x_d;
      acc_y_q <= acc_y_d;
    end
  end

  // Pixel pipeline: stage A holds the bounds test, stage B the address.
  logic            a_valid_q, b_valid_q;
  logic            a_adv, b_adv;
  logic [DW-1:0]   a_row_q, a_col_q;
  logic            a_inside_q, a_last_q;
  logic [XW-1:0]   col_i, row_i;
  logic            inside_c;

  assign b_adv = !b_valid_q || out_ready_i;
  assign a_adv = !a_valid_q || b_adv;

  assign col_i = acc_x_q[CW-1:CW-XW];
  assign row_i = acc_y_q[CW-1:CW-XW];
  // Negative coordinates have the top bit set and so fail the unsigned compare.
  assign inside_c = (col_i < {{(XW-DW){1'b0}}, w_c}) && (row_i < {{(XW-DW){1'b0}}, h_c});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_q <= cmd_i.pix_gen;
      end
      if (b_adv) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_gen) begin
      a_row_q    <= row_i[DW-1:0];
      a_col_q    <= col_i[DW-1:0];
      a_inside_q <= inside_c;
      a_last_q   <= (cnt_q == CntW'(1));
    end
  end

  logic [2*DW-1:0]          row_mul;
  logic [2*DW:0]            addr_sum;
  logic [asag_pkg::AddrW-1:0] b_addr_q;
  logic                     b_inside_q, b_last_q;

  assign row_mul  = (2*DW)'(a_row_q) * (2*DW)'(w_c);
  assign addr_sum = (2*DW+1)'(row_mul) + (2*DW+1)'(a_col_q);

  always_ff @(posedge clk_i) begin
    if (b_adv && a_valid_q) begin
      b_addr_q   <= a_inside_q ? addr_sum[asag_pkg::AddrW-1:0] : '0;
      b_inside_q <= a_inside_q;
      b_last_q   <= a_last_q;
    end
  end

  assign out_valid_o      = b_valid_q;
  assign source_address_o = b_addr_q;
  assign inside_res_o     = b_inside_q;
  assign last_o           = b_last_q;

  assign sts_o.gen_ok   = a_adv;
  assign sts_o.cnt_last = (cnt_q == CntW'(1));
  assign sts_o.cnt_zero = (cnt_q == '0);

endmodule

`default_nettype wire

@@ design/affine_span_source_address_gen_core.sv @@
// Top level of the affine span source address generator.
// Joins asag_ctrl and asag_datapath; types and widths come from asag_pkg.
//
//   channel   direction  handshake                 payload
//   in        request    in_valid_i / in_ready_o   start_x_i, start_y_i, span_length_i
//   out       result     out_valid_o / out_ready_i source_address_o, inside_res_o, last_o
//   cfg       write      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A request is accepted in S_IDLE and its start point mapped through the single
// shared 32x16 multiplier from S_MAP_AX to S_MAP_END; then one pixel a cycle is
// issued while stage A can take it, and leaves after stages A and B.
// Reset restores the identity matrix and a 1x1 source; it clears no memory.
// An output stall holds back pixel issue; a new request is taken while the
// last pixels of the previous one still drain.
`default_nettype none

module affine_span_source_address_gen_core #(
  parameter int unsigned MAX_SPAN = 64,
  parameter int unsigned MAX_DIM  = 4096
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [asag_pkg::CoordW-1:0] start_x_i,
  input  wire logic signed [asag_pkg::CoordW-1:0] start_y_i,
  input  wire logic [asag_pkg::LenW-1:0]          span_length_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [asag_pkg::AddrW-1:0]              source_address_o,
  output logic                                    inside_res_o,
  output logic                                    last_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [asag_pkg::IdxW-1:0]          cfg_index_i,
  input  wire logic [asag_pkg::CoefW-1:0]         cfg_data_i
);

  asag_pkg::cmd_t cmd;
  asag_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  asag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  asag_datapath #(
    .MAX_SPAN (MAX_SPAN),
    .MAX_DIM  (MAX_DIM)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .span_length_i    (span_length_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .source_address_o (source_address_o),
    .inside_res_o     (inside_res_o),
    .last_o           (last_o)
  );

  // Once a request is taken the block is busy mapping it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while mapping");

  // Whenever a request can be taken, every pixel of the previous span is issued.
  a_idle_counter_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> sts.cnt_zero)
    else $error("pixels left while idle");

  // A sample outside the source carries address zero.
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !inside_res_o |-> source_address_o == '0)
    else $error("outside pixel with nonzero address");

  // Pixels are issued only while the controller is not taking requests.
  a_no_issue_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pix_gen |-> !in_ready_o && !sts.cnt_zero)
    else $error("pixel issued outside a span");

endmodule

`default_nettype wire

@@ tb/affine_span_source_address_gen_core_tb.sv @@
// Self-checking testbench for affine_span_source_address_gen_core.
// Holds a span address scoreboard class and the top module that drives the block;
// depends on asag_pkg and the RTL only.
`timescale 1ns / 100ps

typedef struct packed {
  logic [asag_pkg::AddrW-1:0] address;
  logic                       in_bounds;
  logic                       last;
} span_pixel_t;

class span_address_scoreboard #(int unsigned MaxSpan = 64, int unsigned MaxDim = 4096);
  logic [31:0]   coef_xx, coef_xy, offset_x, coef_yx, coef_yy, offset_y;
  logic [12:0]   src_width, src_height;
  span_pixel_t   expected_pixels[$];
  int unsigned   failures;

  function new();
    coef_xx    = 32'h0001_0000;
    coef_xy    = '0;
    offset_x   = '0;
    coef_yx    = '0;
    coef_yy    = 32'h0001_0000;
    offset_y   = '0;
    src_width  = 13'd1;
    src_height = 13'd1;
    failures   = 0;
  endfunction

  function void set_register(asag_pkg::cfg_reg_e idx, logic [31:0] data);
    case (idx)
      asag_pkg::REG_COEF_XX:    coef_xx = data;
      asag_pkg::REG_COEF_XY:    coef_xy = data;
      asag_pkg::REG_OFFSET_X:   offset_x = data;
      asag_pkg::REG_COEF_YX:    coef_yx = data;
      asag_pkg::REG_COEF_YY:    coef_yy = data;
      asag_pkg::REG_OFFSET_Y:   offset_y = data;
      asag_pkg::REG_SRC_WIDTH:  src_width = data[12:0];
      asag_pkg::REG_SRC_HEIGHT: src_height = data[12:0];
      default: ;
    endcase
  endfunction

  // Bits 16..47 of the full signed product of two 16.16 values.
  function logic [31:0] fixed_mul(logic [31:0] p, logic [31:0] q);
    logic signed [63:0] prod;
    prod = $signed(p) * $signed(q);
    return prod[47:16];
  endfunction

  function void note_span(logic signed [15:0] x, logic signed [15:0] y, logic [6:0] len);
    logic [31:0] x_fix, y_fix, pos_x, pos_y;
    int          w, h, col, row, count, i;
    span_pixel_t px;
    x_fix = {x, 16'h0000};
    y_fix = {y, 16'h0000};
    w     = (src_width > MaxDim) ? MaxDim : src_width;
    h     = (src_height > MaxDim) ? MaxDim : src_height;
    count = (len > MaxSpan) ? MaxSpan : len;
    pos_x = fixed_mul(coef_xx, x_fix) + fixed_mul(coef_xy, y_fix) + offset_x;
    pos_y = fixed_mul(coef_yx, x_fix) + fixed_mul(coef_yy, y_fix) + offset_y;
    for (i = 0; i < count; i++) begin
      col       = $signed(pos_x[31:16]);
      row       = $signed(pos_y[31:16]);
      px.in_bounds = (col >= 0) && (col < w) && (row >= 0) && (row < h);
      px.address = px.in_bounds ? 24'(row * w + col) : '0;
      px.last   = (i == count - 1);
      expected_pixels.push_back(px);
      pos_x += coef_xx;
      pos_y += coef_yx;
    end
  endfunction

  function void check_pixel(logic [asag_pkg::AddrW-1:0] address, logic in_bounds, logic last);
    span_pixel_t want;
    if (expected_pixels.size() == 0) begin
      if (failures < 10)
        $display("%0t: pixel with no request pending: address %h inside %b last %b",
                 $time, address, in_bounds, last);
      failures++;
      return;
    end
    want = expected_pixels.pop_front();
    if (want.address !== address || want.in_bounds !== in_bounds || want.last !== last) begin
      if (failures < 10)
        $display("%0t: pixel differs (expected/actual): address %h/%h inside %b/%b last %b/%b",
                 $time, want.address, address, want.in_bounds, in_bounds, want.last, last);
      failures++;
    end
  endfunction

  function int unsigned pending();
    return expected_pixels.size();
  endfunction
endclass

module affine_span_source_address_gen_core_tb;

  localparam int unsigned MAX_SPAN       = 64;
  localparam int unsigned MAX_DIM        = 4096;
  localparam int unsigned SETTLE_CYCLES  = MAX_SPAN + 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET    = 330;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic signed [asag_pkg::CoordW-1:0] start_x_i;
  logic signed [asag_pkg::CoordW-1:0] start_y_i;
  logic [asag_pkg::LenW-1:0]          span_length_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic [asag_pkg::AddrW-1:0]         source_address_o;
  logic                               inside_res_o;
  logic                               last_o;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [asag_pkg::IdxW-1:0]          cfg_index_i;
  logic [asag_pkg::CoefW-1:0]         cfg_data_i;

  span_address_scoreboard #(MAX_SPAN, MAX_DIM) sb;

  int unsigned burst_left    = 0;
  int unsigned spans_sent    = 0;
  int unsigned idle_cycles   = 0;
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [7:0]  pattern_age   = '0;

  affine_span_source_address_gen_core #(
    .MAX_SPAN(MAX_SPAN),
    .MAX_DIM (MAX_DIM)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .span_length_i   (span_length_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .source_address_o(source_address_o),
    .inside_res_o    (inside_res_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver replays a 16-bit stall pattern and picks a fresh one whenever pattern_age wraps.
  // Bit 0 is always set so that every pass through the pattern sets out_ready_i at least once.
  always @(posedge clk_i) begin
    if (pattern_age == 8'd0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern <= 16'hFFFF;
        1:       stall_pattern <= 16'($urandom()) | 16'h0001;
        2:       stall_pattern <= 16'($urandom() | $urandom()) | 16'h0001;
        default: stall_pattern <= 16'($urandom() & $urandom()) | 16'h0001;
      endcase
    end
    pattern_age <= pattern_age + 8'd1;
    out_ready_i <= stall_pattern[pattern_age[3:0]];
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_pixel(source_address_o, inside_res_o, last_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("affine_span_source_address_gen_core: mismatch");
      $finish;
    end
  end

  task automatic send_span(logic signed [15:0] x, logic signed [15:0] y, logic [6:0] len);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 6);
    end
    in_valid_i    <= 1'b1;
    start_x_i     <= x;
    start_y_i     <= y;
    span_length_i <= len;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_span(x, y, len);
    burst_left--;
    spans_sent++;
  endtask

  task automatic write_reg(asag_pkg::cfg_reg_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, data);
  endtask

  task automatic load_matrix(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic [31:0] d, logic [31:0] e, logic [31:0] f,
                             logic [12:0] w, logic [12:0] h);
    write_reg(asag_pkg::REG_COEF_XX, a);
    write_reg(asag_pkg::REG_COEF_XY, b);
    write_reg(asag_pkg::REG_OFFSET_X, c);
    write_reg(asag_pkg::REG_COEF_YX, d);
    write_reg(asag_pkg::REG_COEF_YY, e);
    write_reg(asag_pkg::REG_OFFSET_Y, f);
    // Bits above the 13-bit dimension field must be ignored.
    write_reg(asag_pkg::REG_SRC_WIDTH, {19'($urandom()), w});
    write_reg(asag_pkg::REG_SRC_HEIGHT, {19'($urandom()), h});
    cfg_valid_i <= 1'b0;
  endtask

  // Waits for every pixel, then long enough for a zero-length request still being mapped.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int signed_pick(int unsigned mag);
    return int'($urandom_range(0, 2 * mag)) - int'(mag);
  endfunction

  task automatic random_phase();
    int          w, h, n, k, kind;
    logic [31:0] a, b, c, d, e, f;
    logic [6:0]  len;
    logic [15:0] x, y;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      w = $urandom_range(0, 8191);
      h = $urandom_range(0, 8191);
      load_matrix($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  13'(w), 13'(h));
    end else begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
      a = 32'(signed_pick(32'h0003_0000));
      b = 32'(signed_pick(32'h0001_0000));
      d = 32'(signed_pick(32'h0001_0000));
      e = 32'(signed_pick(32'h0003_0000));
      c = {16'(int'($urandom_range(0, w + 8)) - 4), 16'($urandom())};
      f = {16'(int'($urandom_range(0, h + 8)) - 4), 16'($urandom())};
      load_matrix(a, b, c, d, e, f, 13'(w), 13'(h));
    end
    n = $urandom_range(15, 40);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 31))
        0:       len = 7'd0;
        1, 2:    len = 7'($urandom_range(65, 127));
        3, 4, 5: len = 7'($urandom_range(17, 64));
        default: len = 7'($urandom_range(1, 16));
      endcase
      if (kind == 0 || $urandom_range(0, 7) == 0) begin
        x = 16'($urandom());
        y = 16'($urandom());
      end else begin
        x = 16'(signed_pick(40) + 20);
        y = 16'(signed_pick(40) + 20);
      end
      send_span(x, y, len);
    end
    settle();
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    start_x_i     = '0;
    start_y_i     = '0;
    span_length_i = '0;
    out_ready_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = asag_pkg::REG_COEF_XX;
    cfg_data_i    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity matrix over a 1x1 source straight out of reset.
    send_span(16'sd0, 16'sd0, 7'd1);
    send_span(16'sd0, 16'sd0, 7'd2);
    send_span(-16'sd1, 16'sd0, 7'd1);
    send_span(16'sd0, -16'sd1, 7'd1);
    send_span(16'sd0, 16'sd0, 7'd0);
    send_span(16'sh7FFF, 16'sh7FFF, 7'd1);
    send_span(16'sh8000, 16'sh8000, 7'd3);
    settle();

    // 16x8 source: spans that cross the right edge, the bottom row and the left edge.
    load_matrix(32'h0001_0000, '0, '0, '0, 32'h0001_0000, '0, 13'd16, 13'd8);
    send_span(16'sd10, 16'sd2, 7'd10);
    send_span(-16'sd3, 16'sd7, 7'd5);
    send_span(16'sd0, 16'sd8, 7'd4);
    send_span(16'sd0, 16'sd0, 7'd64);
    send_span(16'sd5, 16'sd3, 7'd65);
    send_span(16'sd1, 16'sd1, 7'd127);
    send_span(16'sd2, 16'sd2, 7'd0);
    settle();

    // Fractional steps with negative terms on the largest source.
    load_matrix(32'h0000_8000, 32'hFFFF_C000, 32'h0002_8000, 32'h0000_C000,
                32'h0001_0000, 32'hFFFF_0000, 13'd4096, 13'd4096);
    send_span(16'sd100, 16'sd200, 7'd40);
    send_span(-16'sd20, -16'sd7, 7'd30);
    settle();

    // A zero width hides everything; the oversized height is clamped.
    load_matrix(32'h0001_0000, '0, '0, '0, 32'h0001_0000, '0, 13'd0, 13'd8191);
    send_span(16'sd0, 16'sd0, 7'd4);
    settle();

    // Extreme coefficients and offsets so that every product and sum wraps.
    load_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 13'd8191, 13'd8191);
    send_span(16'sh8000, 16'sh7FFF, 7'd8);
    send_span(16'sh7FFF, 16'sh8000, 7'd8);
    settle();

    while (spans_sent < ITEM_TARGET) random_phase();

    if (sb.failures == 0 && sb.pending() == 0)
      $display("affine_span_source_address_gen_core: match");
    else
      $display("affine_span_source_address_gen_core: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
design/asag_pkg.sv
design/asag_ctrl.sv
design/asag_datapath.sv
design/affine_span_source_address_gen_core.sv
tb/affine_span_source_address_gen_core_tb.sv
